@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file of the merge sorter.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define MS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define MS_ASSERT_IMP(label, ante, cons, msg) \
    `MS_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define MS_ASSERT_NXT(label, ante, cons, msg) \
    `MS_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ hw/rtl/ms_pkg.sv @@
// Shared constants and control bundle for the merge sorter.
// No dependencies; imported by ms_seq, merge_sorter, ms_checker and the testbench.
`timescale 1ns / 1ps

package ms_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    // Control from the sequencer to the memory datapath.
    typedef struct packed {
        logic load_we;   // write an incoming word into buffer 0
        logic merge_we;  // write a merged word into the destination buffer
        logic take_a;    // merged word comes from the lower run head
        logic src_sel;   // buffer that is read in this phase
        logic dst_sel;   // buffer that is written by a merge pass
    } ms_ctl_t;

endpackage

@@ hw/rtl/ms_ram.sv @@
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Depends on nothing; instanced twice as the ping-pong sort buffers.
`timescale 1ns / 1ps

module ms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ hw/rtl/ms_seq.sv @@
// Sequencer of the merge sorter: load counter, bottom-up merge pointers, output index.
// Depends on ms_pkg; drives the addresses and write controls of both buffers.
`timescale 1ns / 1ps

module ms_seq
    import ms_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_last,
    output logic                         in_ready,
    output logic                         out_valid,
    output logic                         out_last,
    output logic                         out_ovf,
    input  logic                         out_ready,
    input  logic                         le_ab,
    output ms_ctl_t                      ctl,
    output logic [$clog2(MAX_ITEMS)-1:0] waddr,
    output logic [$clog2(MAX_ITEMS)-1:0] raddr_a,
    output logic [$clog2(MAX_ITEMS)-1:0] raddr_b
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = CW + 2;

    localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_MERGE = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [PW-1:0] wid_reg, wid_next;
    logic [PW-1:0] lo_reg, lo_next;
    logic [PW-1:0] mid_reg, mid_next;
    logic [PW-1:0] hi_reg, hi_next;
    logic [PW-1:0] i_reg, i_next;
    logic [PW-1:0] j_reg, j_next;
    logic [PW-1:0] k_reg, k_next;
    logic          src_reg, src_next;
    logic          oval_reg, oval_next;

    logic [PW-1:0] n_ext;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] n_new;
    logic          room;
    logic [PW-1:0] mid_c;
    logic [PW-1:0] hi_c;
    logic [PW-1:0] wid2;
    logic [PW-1:0] wa_p;
    logic [PW-1:0] ra_p;
    logic [PW-1:0] rb_p;
    logic          take;
    logic          last_c;

    assign n_ext   = PW'(cnt_reg);
    assign cnt_inc = cnt_reg + CW'(1);
    assign room    = (cnt_reg != MAX_C);
    assign n_new   = room ? cnt_inc : cnt_reg;
    assign wid2    = wid_reg << 1;
    assign last_c  = ((k_reg + PW'(1)) == n_ext);

    // Run bounds of the next merge, clipped to the set size.
    always_comb
    begin
        mid_c = lo_reg + wid_reg;
        if (mid_c > n_ext)
        begin
            mid_c = n_ext;
        end
        hi_c = lo_reg + wid2;
        if (hi_c > n_ext)
        begin
            hi_c = n_ext;
        end
    end

    assign take = (i_reg != mid_reg) && ((j_reg == hi_reg) || le_ab);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        wid_next   = wid_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        src_next   = src_reg;
        oval_next  = oval_reg;
        ctl        = '0;
        ctl.src_sel = src_reg;
        ctl.dst_sel = !src_reg;
        wa_p       = k_reg;
        ra_p       = k_reg;
        rb_p       = j_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                wa_p = PW'(cnt_reg);
                if (in_valid)
                begin
                    if (room)
                    begin
                        ctl.load_we = 1'b1;
                        cnt_next    = cnt_inc;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        cnt_next = n_new;
                        src_next = 1'b0;
                        wid_next = PW'(1);
                        lo_next  = '0;
                        k_next   = '0;
                        if (n_new > CW'(1))
                        begin
                            state_next = S_SETUP;
                        end
                        else
                        begin
                            oval_next  = 1'b0;
                            state_next = S_OUT;
                        end
                    end
                end
            end

            S_SETUP:
            begin
                // issue reads of both run heads
                mid_next   = mid_c;
                hi_next    = hi_c;
                i_next     = lo_reg;
                j_next     = mid_c;
                k_next     = lo_reg;
                ra_p       = lo_reg;
                rb_p       = mid_c;
                state_next = S_MERGE;
            end

            S_MERGE:
            begin
                ctl.merge_we = 1'b1;
                ctl.take_a   = take;
                wa_p         = k_reg;
                i_next       = i_reg + PW'(take);
                j_next       = j_reg + PW'(!take);
                ra_p         = i_next;
                rb_p         = j_next;
                k_next       = k_reg + PW'(1);
                if (k_next == hi_reg)
                begin
                    state_next = S_SETUP;
                    lo_next    = hi_reg;
                    if (hi_reg == n_ext)
                    begin
                        // pass done: merged buffer becomes the source
                        src_next = !src_reg;
                        wid_next = wid2;
                        lo_next  = '0;
                        if (wid2 >= n_ext)
                        begin
                            k_next     = '0;
                            oval_next  = 1'b0;
                            state_next = S_OUT;
                        end
                    end
                end
            end

            S_OUT:
            begin
                ra_p = k_reg;
                if (!oval_reg)
                begin
                    oval_next = 1'b1;
                end
                else if (out_ready)
                begin
                    if (last_c)
                    begin
                        oval_next  = 1'b0;
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        src_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next = k_reg + PW'(1);
                        ra_p   = k_next;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            wid_reg   <= '0;
            lo_reg    <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            src_reg   <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            wid_reg   <= wid_next;
            lo_reg    <= lo_next;
            mid_reg   <= mid_next;
            hi_reg    <= hi_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            src_reg   <= src_next;
            oval_reg  <= oval_next;
        end
    end

    assign waddr     = wa_p[AW-1:0];
    assign raddr_a   = ra_p[AW-1:0];
    assign raddr_b   = rb_p[AW-1:0];
    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = oval_reg;
    assign out_last  = oval_reg && last_c;
    assign out_ovf   = ovf_reg;

endmodule

@@ hw/rtl/merge_sorter.sv @@
// Merge sorter: loads a set of signed words, sorts them stably, streams them out.
// Top level; depends on ms_pkg, ms_seq and ms_ram.
//
// Usage:
//   s_axis carries one signed 32-bit word per beat; tlast closes the set.
//   Words beyond MAX_ITEMS are dropped and every output word of that set
//   then carries tuser = 1.
//   m_axis returns the set in ascending order, equal words in arrival order,
//   tlast on the final word, tuser = overflow flag.
// Flow, for a set of n words (n >= 2): the load, then ceil(log2 n) merge
//   passes with one setup step per pair of runs (a lone tail run counts as
//   one pair), then the read of the first word and the output of all n words.
//   The merge passes are bound by the single write port of the buffer
//   memories.
// s_axis_tready is high only while loading; the next set starts loading
// after the final word of the current set is taken.
// A stall on m_axis holds the current word on the read port of the memory.
// Reset returns the block to loading an empty set; memory contents are kept.
`timescale 1ns / 1ps

module merge_sorter
    import ms_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
    output logic              m_axis_tlast,
    output logic              m_axis_tuser    // [0] overflow
);

    localparam int AW = $clog2(MAX_ITEMS);

    ms_ctl_t           ctl;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr_a;
    logic [AW-1:0]     raddr_b;
    logic [DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
    logic [DATA_W-1:0] head_a;
    logic [DATA_W-1:0] head_b;
    logic [DATA_W-1:0] wdata;
    logic              le_ab;
    logic              we0;
    logic              we1;

    ms_seq #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_last  (m_axis_tlast),
        .out_ovf   (m_axis_tuser),
        .out_ready (m_axis_tready),
        .le_ab     (le_ab),
        .ctl       (ctl),
        .waddr     (waddr),
        .raddr_a   (raddr_a),
        .raddr_b   (raddr_b)
    );

    // Heads of the two runs come from the current source buffer.
    assign head_a = ctl.src_sel ? rd1_a : rd0_a;
    assign head_b = ctl.src_sel ? rd1_b : rd0_b;
    assign le_ab  = ($signed(head_a) <= $signed(head_b));

    assign wdata = ctl.load_we ? s_axis_tdata : (ctl.take_a ? head_a : head_b);
    assign we0   = ctl.load_we || (ctl.merge_we && !ctl.dst_sel);
    assign we1   = ctl.merge_we && ctl.dst_sel;

    ms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_buf0 (
        .clk     (clk),
        .we      (we0),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    ms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_buf1 (
        .clk     (clk),
        .we      (we1),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

    assign m_axis_tdata = head_a;

endmodule

@@ hw/rtl/ms_checker.sv @@
// Port-level checks of the merge sorter, bound to the top level.
// Depends on ms_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ms_checker
    import ms_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic              m_axis_tlast,
    input logic              m_axis_tuser
);

    `MS_ASSERT(a_no_load_while_out, !(s_axis_tready && m_axis_tvalid), "load during output")

    `MS_ASSERT_NXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled word changed")

    `MS_ASSERT_NXT(a_end_of_set, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid && s_axis_tready, "no return to load after final word")

    `MS_ASSERT_NXT(a_ovf_steady, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && $stable(m_axis_tuser), "overflow flag changed within a set")

endmodule

bind merge_sorter ms_checker u_ms_checker (.*);

@@ test/testbench.sv @@
// Self-checking bench for merge_sorter: loads signed word sets, checks sorted order and flags.
// Depends on ms_pkg and the merge_sorter RTL; reads no files.
`timescale 1ns / 1ps

module testbench;
    import ms_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int RANDOM_WORDS = 250;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     ovf;
    } sorted_word_t;

    // Tracks the set being loaded and the sorted words still owed by the block.
    class sort_board;
        logic signed [DATA_W-1:0] held[$];
        bit                       dropped;
        sorted_word_t             due[$];
        int                       errors;

        task report(input string msg);
            $display("ERROR %0t: %s", $time, msg);
            errors++;
        endtask

        // Store or drop the word; on the closing word build the sorted set.
        function void note_word(input logic signed [DATA_W-1:0] v, input logic l);
            logic signed [DATA_W-1:0] ordered[$];
            sorted_word_t             w;
            int                       p;
            if (held.size() < MAX_ITEMS_DEF)
                held.push_back(v);
            else
                dropped = 1'b1;
            if (!l)
                return;
            // insert after every equal word so arrival order survives
            foreach (held[i])
            begin
                p = 0;
                while (p < ordered.size() && ordered[p] <= held[i])
                    p++;
                ordered.insert(p, held[i]);
            end
            foreach (ordered[k])
            begin
                w.value = ordered[k];
                w.last  = (k == ordered.size() - 1);
                w.ovf   = dropped;
                due.push_back(w);
            end
            held.delete();
            dropped = 1'b0;
        endfunction

        task check_word(input logic signed [DATA_W-1:0] v, input logic l, input logic o);
            sorted_word_t w;
            if (due.size() == 0)
            begin
                report($sformatf("unexpected word %0d", v));
                return;
            end
            w = due.pop_front();
            if (v !== w.value)
                report($sformatf("value %0d, want %0d", v, w.value));
            if (l !== w.last)
                report($sformatf("tlast %b, want %b (value %0d)", l, w.last, w.value));
            if (o !== w.ovf)
                report($sformatf("tuser %b, want %b (value %0d)", o, w.ovf, w.value));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;
    logic              m_axis_tlast;
    logic              m_axis_tuser;

    sort_board board = new();
    bit        quiet;
    int        words_sent;

    merge_sorter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly no gap, some short, a few long; none while quiet.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3, 4: return $unsigned($signed($urandom_range(0, 6)) - 3);
            default: return $urandom;
        endcase
    endfunction

    task send_word(input logic [DATA_W-1:0] v, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= l;
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
    endtask

    task send_set(input logic [DATA_W-1:0] vals[$]);
        foreach (vals[i])
            send_word(vals[i], i == vals.size() - 1);
    endtask

    task automatic send_random_set(input int size);
        logic [DATA_W-1:0] vals[$];
        repeat (size) vals.push_back(pick_value());
        quiet = ($urandom_range(0, 4) == 0);
        send_set(vals);
    endtask

    // Receiver with random stalls.
    initial
    begin
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Note accepted input words before checking output words of the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_word($signed(s_axis_tdata), s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                board.check_word($signed(m_axis_tdata), m_axis_tlast, m_axis_tuser);
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int set_idx;
        int size;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        rst_n         = 1'b0;
        quiet         = 1'b1;
        words_sent    = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single word, extremes, equal words, reversed order.
        send_set('{32'h8000_0000});
        send_set('{32'h7FFF_FFFF, 32'h8000_0000});
        quiet = 1'b0;
        send_set('{32'h0, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h0});
        send_set('{32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF,
                   32'h8000_0001, 32'h7FFF_FFFE});
        send_set('{32'd5, 32'd4, 32'd3, 32'd2, 32'd1, 32'd0, 32'hFFFF_FFFF});

        // Random sets; a few fill the store exactly or run past it.
        set_idx    = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            case (set_idx)
                2: size = MAX_ITEMS_DEF;
                5: size = MAX_ITEMS_DEF + 1;
                9: size = MAX_ITEMS_DEF + $urandom_range(2, 8);
                default:
                    if ($urandom_range(0, 19) == 0)
                        size = $urandom_range(MAX_ITEMS_DEF - 4, MAX_ITEMS_DEF + 6);
                    else
                        size = $urandom_range(1, 12);
            endcase
            send_random_set(size);
            set_idx++;
        end
        s_axis_tvalid <= 1'b0;
        // let the monitor note the closing word before waiting on the queue
        @(posedge clk);

        while (board.due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ms_pkg.sv
hw/rtl/ms_ram.sv
hw/rtl/ms_seq.sv
hw/rtl/merge_sorter.sv
hw/rtl/ms_checker.sv
test/testbench.sv
